// File: hw/rtl/bfic_pkg.sv
// ----------------------------------------------------------------------------
// bfic_pkg
// shared types, sizes, character codes and command encodings of the core
// ----------------------------------------------------------------------------
package bfic_pkg;

  // memory sizes
  localparam int unsigned PROG_DEPTH = 4096;
  localparam int unsigned TAPE_DEPTH = 1024;
  localparam int unsigned CLR_DEPTH  = (PROG_DEPTH > TAPE_DEPTH) ? PROG_DEPTH : TAPE_DEPTH;

  localparam int unsigned PA_W  = $clog2(PROG_DEPTH);
  localparam int unsigned PC_W  = PA_W + 1;
  localparam int unsigned TA_W  = $clog2(TAPE_DEPTH);
  localparam int unsigned CLR_W = $clog2(CLR_DEPTH);

  // program characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_EXEC    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OUT = 2'd1,
    ST_END = 2'd2,
    ST_ERR = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RS_RUN = 2'd0,
    RS_END = 2'd1,
    RS_ERR = 2'd2
  } run_e;

  typedef enum logic [2:0] {
    OP_ZERO,
    OP_RIGHT,
    OP_LEFT,
    OP_PLUS,
    OP_MINUS,
    OP_DOT,
    OP_OPEN,
    OP_CLOSE
  } op_e;

  // OP_OTHER shares no code with the above: handled by a separate flag
  typedef enum logic [1:0] {
    RA_PC,
    RA_P,
    RA_PM1
  } ra_sel_e;

  typedef enum logic [1:0] {
    PC_HOLD,
    PC_INC,
    PC_P,
    PC_P1
  } pc_op_e;

  typedef enum logic [2:0] {
    P_HOLD,
    P_FWD_INIT,
    P_BWD_INIT,
    P_INC,
    P_DEC
  } p_op_e;

  typedef enum logic [1:0] {
    D_HOLD,
    D_INIT,
    D_INC,
    D_DEC
  } depth_op_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FRD,
    S_FCHK,
    S_BRD,
    S_BCHK,
    S_TCLR,
    S_RESP
  } state_e;

  // controller to datapath
  typedef struct packed {
    ra_sel_e   ra_sel;
    logic      prog_wr;
    logic      clr_prog;
    logic      clr_tape;
    logic      clr_reset;
    logic      run_clear;
    logic      rs_set;
    run_e      rs_val;
    logic      dp_inc;
    logic      dp_dec;
    logic      cell_inc;
    logic      cell_dec;
    pc_op_e    pc_op;
    p_op_e     p_op;
    depth_op_e depth_op;
    logic      res_set;
    status_e   res_status;
    logic      res_emit;
    logic      out_load;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    run_e run_state;
    logic pc_end;
    op_e  op;
    logic op_other;
    logic cell_zero;
    logic dp_max;
    logic dp_zero;
    logic p_end;
    logic p_zero;
    logic depth_one;
    logic clr_last_all;
    logic clr_last_tape;
  } stat_t;

  // instruction class of a program byte
  function automatic op_e op_decode(input logic [7:0] b);
    op_e o;
    o = OP_ZERO;
    case (b)
      CH_NUL:   o = OP_ZERO;
      CH_RIGHT: o = OP_RIGHT;
      CH_LEFT:  o = OP_LEFT;
      CH_PLUS:  o = OP_PLUS;
      CH_MINUS: o = OP_MINUS;
      CH_DOT:   o = OP_DOT;
      CH_OPEN:  o = OP_OPEN;
      CH_CLOSE: o = OP_CLOSE;
      default:  o = OP_ZERO;
    endcase
    return o;
  endfunction

  // true for nonzero bytes that are no instruction (input ',' included)
  function automatic logic op_is_other(input logic [7:0] b);
    logic r;
    r = 1'b0;
    case (b)
      CH_NUL, CH_RIGHT, CH_LEFT, CH_PLUS, CH_MINUS,
      CH_DOT, CH_OPEN, CH_CLOSE: r = 1'b0;
      CH_COMMA: r = 1'b1;
      default:  r = 1'b1;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/brainfuck_interpreter_core_top.sv
// ----------------------------------------------------------------------------
// brainfuck_interpreter_core_top
// interpreter core: program store, 8-bit tape, one command item per result
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_stall_o) carries cmd_i, prog_addr_i and
//   prog_byte_i; every accepted item yields exactly one result item on the
//   output channel (out_valid_o / out_stall_i) with status_o, out_byte_o and
//   pc_now_o
// sequence, item accept to result valid
//   load, no-op, exec while stopped: straight to the result stage
//   exec of an ordinary instruction: program and tape reads share one
//     registered read, then decode, then the result stage
//   bracket jump: decode, then a read state and a check state per program
//     byte scanned, then the result stage, as there is one program read port
//   restart: one tape cell zeroed per cycle, then the result stage
//   one item is in flight at a time
// reset
//   after rst_ni is released the core zeroes all PROG_DEPTH (4096) program
//   addresses and the tape with in_stall_o high, then accepts items
// back pressure
//   a result waits in the output register while out_stall_i is high; the
//   next item is still accepted and runs, and holds its own result until
//   the output register frees up
module brainfuck_interpreter_core_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                cmd_i,
  input  logic [bfic_pkg::PA_W-1:0] prog_addr_i,
  input  logic [7:0]                prog_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [7:0]                out_byte_o,
  output logic [bfic_pkg::PC_W-1:0] pc_now_o
);
  import bfic_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  // sequencer: handshake, instruction decode, scan and clear control
  bfic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl),
    .stat_i      (stat)
  );

  // memories, pointers and result registers
  bfic_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .prog_addr_i (prog_addr_i),
    .prog_byte_i (prog_byte_i),
    .status_o    (status_o),
    .out_byte_o  (out_byte_o),
    .pc_now_o    (pc_now_o)
  );

`ifndef SYNTHESIS
  // only an output instruction carries a nonzero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OUT) |-> (out_byte_o == 8'h00))
    else $error("nonzero out_byte without output status");

  // one item in flight: an accepted item blocks the input next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item accepted while one is in flight");

  // no tape update while the input side is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !(ctl.cell_inc || ctl.cell_dec || ctl.clr_tape))
    else $error("tape write while idle");

  // a result is loaded only when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("result overwrote a stalled output item");
`endif

endmodule

// File: hw/rtl/bfic_dp.sv
// ----------------------------------------------------------------------------
// bfic_dp
// datapath: program and tape memories, pointers, scan counters, result regs
// ----------------------------------------------------------------------------
module bfic_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bfic_pkg::ctl_t             ctl_i,
  output bfic_pkg::stat_t            stat_o,
  input  logic [bfic_pkg::PA_W-1:0]  prog_addr_i,
  input  logic [7:0]                 prog_byte_i,
  output logic [1:0]                 status_o,
  output logic [7:0]                 out_byte_o,
  output logic [bfic_pkg::PC_W-1:0]  pc_now_o
);
  import bfic_pkg::*;

  logic [7:0] prog_mem [PROG_DEPTH];
  logic [7:0] tape_mem [TAPE_DEPTH];

  logic [PC_W-1:0]  pc_q, pc_d;
  logic [TA_W-1:0]  dptr_q, dptr_d;
  logic [PC_W-1:0]  p_q, p_d;
  logic [PC_W-1:0]  p_dec;
  logic [PC_W-1:0]  depth_q, depth_d;
  run_e             rs_q, rs_d;
  logic [CLR_W-1:0] clr_q, clr_d;

  logic [7:0]       prog_rdata_q;
  logic [7:0]       tape_rdata_q;
  status_e          pend_status_q;
  logic [7:0]       pend_byte_q;
  logic [1:0]       out_status_q;
  logic [7:0]       out_byte_q;
  logic [PC_W-1:0]  out_pc_q;

  logic [PA_W-1:0]  prog_ra;
  logic             prog_we;
  logic [PA_W-1:0]  prog_wa;
  logic [7:0]       prog_wd;
  logic             clr_in_prog;
  logic             clr_in_tape;
  logic             tape_clr;
  logic             tape_we;
  logic [TA_W-1:0]  tape_wa;
  logic [7:0]       tape_wd;

  assign p_dec = p_q - PC_W'(1);

  always_comb begin
    pc_d = pc_q;
    if (ctl_i.run_clear) begin
      pc_d = '0;
    end else begin
      case (ctl_i.pc_op)
        PC_HOLD: pc_d = pc_q;
        PC_INC:  pc_d = pc_q + PC_W'(1);
        PC_P:    pc_d = p_q;
        PC_P1:   pc_d = p_q + PC_W'(1);
        default: pc_d = pc_q;
      endcase
    end
  end

  always_comb begin
    dptr_d = dptr_q;
    if (ctl_i.run_clear) begin
      dptr_d = '0;
    end else if (ctl_i.dp_inc) begin
      dptr_d = dptr_q + TA_W'(1);
    end else if (ctl_i.dp_dec) begin
      dptr_d = dptr_q - TA_W'(1);
    end
  end

  always_comb begin
    rs_d = rs_q;
    if (ctl_i.run_clear) begin
      rs_d = RS_RUN;
    end else if (ctl_i.rs_set) begin
      rs_d = ctl_i.rs_val;
    end
  end

  always_comb begin
    case (ctl_i.p_op)
      P_HOLD:     p_d = p_q;
      P_FWD_INIT: p_d = pc_q + PC_W'(1);
      P_BWD_INIT: p_d = pc_q;
      P_INC:      p_d = p_q + PC_W'(1);
      P_DEC:      p_d = p_dec;
      default:    p_d = p_q;
    endcase
  end

  always_comb begin
    case (ctl_i.depth_op)
      D_HOLD:  depth_d = depth_q;
      D_INIT:  depth_d = PC_W'(1);
      D_INC:   depth_d = depth_q + PC_W'(1);
      D_DEC:   depth_d = depth_q - PC_W'(1);
      default: depth_d = depth_q;
    endcase
  end

  always_comb begin
    clr_d = clr_q;
    if (ctl_i.clr_reset) begin
      clr_d = '0;
    end else if (ctl_i.clr_prog || ctl_i.clr_tape) begin
      clr_d = clr_q + CLR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= '0;
      dptr_q  <= '0;
      p_q     <= '0;
      depth_q <= '0;
      rs_q    <= RS_RUN;
      clr_q   <= '0;
    end else begin
      pc_q    <= pc_d;
      dptr_q  <= dptr_d;
      p_q     <= p_d;
      depth_q <= depth_d;
      rs_q    <= rs_d;
      clr_q   <= clr_d;
    end
  end

  // program memory: one write port, one registered read port
  assign clr_in_prog = ({1'b0, clr_q} < (CLR_W+1)'(PROG_DEPTH));
  assign prog_we = ctl_i.prog_wr || (ctl_i.clr_prog && clr_in_prog);
  assign prog_wa = ctl_i.prog_wr ? prog_addr_i : clr_q[PA_W-1:0];
  assign prog_wd = ctl_i.prog_wr ? prog_byte_i : 8'h00;

  always_comb begin
    case (ctl_i.ra_sel)
      RA_PC:   prog_ra = pc_q[PA_W-1:0];
      RA_P:    prog_ra = p_q[PA_W-1:0];
      RA_PM1:  prog_ra = p_dec[PA_W-1:0];
      default: prog_ra = pc_q[PA_W-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (prog_we) begin
      prog_mem[prog_wa] <= prog_wd;
    end
    prog_rdata_q <= prog_mem[prog_ra];
  end

  // tape memory: read always at the data pointer
  assign clr_in_tape = ({1'b0, clr_q} < (CLR_W+1)'(TAPE_DEPTH));
  assign tape_clr = ctl_i.clr_tape && clr_in_tape;
  assign tape_we  = tape_clr || ctl_i.cell_inc || ctl_i.cell_dec;
  assign tape_wa  = tape_clr ? clr_q[TA_W-1:0] : dptr_q;
  assign tape_wd  = tape_clr       ? 8'h00 :
                    ctl_i.cell_inc ? tape_rdata_q + 8'd1 :
                                     tape_rdata_q - 8'd1;

  always_ff @(posedge clk_i) begin
    if (tape_we) begin
      tape_mem[tape_wa] <= tape_wd;
    end
    tape_rdata_q <= tape_mem[dptr_q];
  end

  // pending result and output register
  always_ff @(posedge clk_i) begin
    if (ctl_i.res_set) begin
      pend_status_q <= ctl_i.res_status;
      pend_byte_q   <= ctl_i.res_emit ? tape_rdata_q : 8'h00;
    end
    if (ctl_i.out_load) begin
      out_status_q <= pend_status_q;
      out_byte_q   <= pend_byte_q;
      out_pc_q     <= pc_q;
    end
  end

  assign status_o   = out_status_q;
  assign out_byte_o = out_byte_q;
  assign pc_now_o   = out_pc_q;

  always_comb begin
    stat_o.run_state     = rs_q;
    stat_o.pc_end        = (pc_q >= PC_W'(PROG_DEPTH));
    stat_o.op            = op_decode(prog_rdata_q);
    stat_o.op_other      = op_is_other(prog_rdata_q);
    stat_o.cell_zero     = (tape_rdata_q == 8'h00);
    stat_o.dp_max        = (dptr_q == TA_W'(TAPE_DEPTH - 1));
    stat_o.dp_zero       = (dptr_q == '0);
    stat_o.p_end         = (p_q >= PC_W'(PROG_DEPTH));
    stat_o.p_zero        = (p_q == '0);
    stat_o.depth_one     = (depth_q == PC_W'(1));
    stat_o.clr_last_all  = (clr_q == CLR_W'(CLR_DEPTH - 1));
    stat_o.clr_last_tape = (clr_q == CLR_W'(TAPE_DEPTH - 1));
  end

endmodule

// File: hw/rtl/bfic_ctrl.sv
// ----------------------------------------------------------------------------
// bfic_ctrl
// controller: item handshake, instruction sequencing, bracket scans, clears
// ----------------------------------------------------------------------------
module bfic_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      cmd_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bfic_pkg::ctl_t  ctl_o,
  input  bfic_pkg::stat_t stat_i
);
  import bfic_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clr_last_all) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          case (cmd_i)
            CMD_RESTART: state_d = S_TCLR;
            CMD_EXEC: begin
              if (stat_i.run_state == RS_RUN && !stat_i.pc_end) state_d = S_EXEC;
              else state_d = S_RESP;
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_EXEC: begin
        if (stat_i.op == OP_OPEN && !stat_i.op_other && stat_i.cell_zero) begin
          state_d = S_FRD;
        end else if (stat_i.op == OP_CLOSE && !stat_i.op_other && !stat_i.cell_zero) begin
          state_d = S_BRD;
        end else begin
          state_d = S_RESP;
        end
      end
      S_FRD: begin
        if (stat_i.p_end) state_d = S_RESP;
        else state_d = S_FCHK;
      end
      S_FCHK: begin
        if (stat_i.op_other) state_d = S_FRD;
        else if (stat_i.op == OP_ZERO) state_d = S_RESP;
        else if (stat_i.op == OP_CLOSE && stat_i.depth_one) state_d = S_RESP;
        else state_d = S_FRD;
      end
      S_BRD: begin
        if (stat_i.p_zero) state_d = S_RESP;
        else state_d = S_BCHK;
      end
      S_BCHK: begin
        if (!stat_i.op_other && stat_i.op == OP_OPEN && stat_i.depth_one) state_d = S_RESP;
        else state_d = S_BRD;
      end
      S_TCLR: begin
        if (stat_i.clr_last_tape) state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o = '0;
    ctl_o.ra_sel     = RA_PC;
    ctl_o.rs_val     = RS_RUN;
    ctl_o.pc_op      = PC_HOLD;
    ctl_o.p_op       = P_HOLD;
    ctl_o.depth_op   = D_HOLD;
    ctl_o.res_status = ST_OK;
    in_stall_o       = 1'b1;
    case (state_q)
      S_CLEAR: begin
        ctl_o.clr_prog = 1'b1;
        ctl_o.clr_tape = 1'b1;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (cmd_i)
            CMD_LOAD: begin
              ctl_o.prog_wr = 1'b1;
              ctl_o.res_set = 1'b1;
            end
            CMD_RESTART: begin
              ctl_o.run_clear = 1'b1;
              ctl_o.clr_reset = 1'b1;
            end
            CMD_EXEC: begin
              if (stat_i.run_state == RS_END) begin
                ctl_o.res_set    = 1'b1;
                ctl_o.res_status = ST_END;
              end else if (stat_i.run_state == RS_ERR) begin
                ctl_o.res_set    = 1'b1;
                ctl_o.res_status = ST_ERR;
              end else if (stat_i.pc_end) begin
                ctl_o.rs_set     = 1'b1;
                ctl_o.rs_val     = RS_END;
                ctl_o.res_set    = 1'b1;
                ctl_o.res_status = ST_END;
              end
            end
            default: begin
              ctl_o.res_set = 1'b1;
            end
          endcase
        end
      end
      S_EXEC: begin
        if (stat_i.op_other) begin
          ctl_o.pc_op   = PC_INC;
          ctl_o.res_set = 1'b1;
        end else begin
          case (stat_i.op)
            OP_ZERO: begin
              ctl_o.rs_set     = 1'b1;
              ctl_o.rs_val     = RS_END;
              ctl_o.res_set    = 1'b1;
              ctl_o.res_status = ST_END;
            end
            OP_RIGHT, OP_LEFT: begin
              ctl_o.res_set = 1'b1;
              if ((stat_i.op == OP_RIGHT && stat_i.dp_max) ||
                  (stat_i.op == OP_LEFT && stat_i.dp_zero)) begin
                ctl_o.rs_set     = 1'b1;
                ctl_o.rs_val     = RS_ERR;
                ctl_o.res_status = ST_ERR;
              end else begin
                ctl_o.dp_inc = (stat_i.op == OP_RIGHT);
                ctl_o.dp_dec = (stat_i.op == OP_LEFT);
                ctl_o.pc_op  = PC_INC;
              end
            end
            OP_PLUS: begin
              ctl_o.cell_inc = 1'b1;
              ctl_o.pc_op    = PC_INC;
              ctl_o.res_set  = 1'b1;
            end
            OP_MINUS: begin
              ctl_o.cell_dec = 1'b1;
              ctl_o.pc_op    = PC_INC;
              ctl_o.res_set  = 1'b1;
            end
            OP_DOT: begin
              ctl_o.pc_op      = PC_INC;
              ctl_o.res_set    = 1'b1;
              ctl_o.res_status = ST_OUT;
              ctl_o.res_emit   = 1'b1;
            end
            OP_OPEN: begin
              if (stat_i.cell_zero) begin
                ctl_o.p_op     = P_FWD_INIT;
                ctl_o.depth_op = D_INIT;
              end else begin
                ctl_o.pc_op   = PC_INC;
                ctl_o.res_set = 1'b1;
              end
            end
            OP_CLOSE: begin
              if (!stat_i.cell_zero) begin
                ctl_o.p_op     = P_BWD_INIT;
                ctl_o.depth_op = D_INIT;
              end else begin
                ctl_o.pc_op   = PC_INC;
                ctl_o.res_set = 1'b1;
              end
            end
            default: begin
              ctl_o.pc_op   = PC_INC;
              ctl_o.res_set = 1'b1;
            end
          endcase
        end
      end
      S_FRD: begin
        ctl_o.ra_sel = RA_P;
        if (stat_i.p_end) begin
          ctl_o.pc_op      = PC_P;
          ctl_o.rs_set     = 1'b1;
          ctl_o.rs_val     = RS_END;
          ctl_o.res_set    = 1'b1;
          ctl_o.res_status = ST_END;
        end
      end
      S_FCHK: begin
        if (stat_i.op_other) begin
          ctl_o.p_op = P_INC;
        end else if (stat_i.op == OP_ZERO) begin
          // unmatched open bracket runs into the end of the program
          ctl_o.pc_op      = PC_P;
          ctl_o.rs_set     = 1'b1;
          ctl_o.rs_val     = RS_END;
          ctl_o.res_set    = 1'b1;
          ctl_o.res_status = ST_END;
        end else if (stat_i.op == OP_OPEN) begin
          ctl_o.depth_op = D_INC;
          ctl_o.p_op     = P_INC;
        end else if (stat_i.op == OP_CLOSE && stat_i.depth_one) begin
          ctl_o.pc_op   = PC_P1;
          ctl_o.res_set = 1'b1;
        end else if (stat_i.op == OP_CLOSE) begin
          ctl_o.depth_op = D_DEC;
          ctl_o.p_op     = P_INC;
        end else begin
          ctl_o.p_op = P_INC;
        end
      end
      S_BRD: begin
        ctl_o.ra_sel = RA_PM1;
        if (stat_i.p_zero) begin
          // unmatched close bracket resumes after position 0
          ctl_o.pc_op   = PC_P1;
          ctl_o.res_set = 1'b1;
        end else begin
          ctl_o.p_op = P_DEC;
        end
      end
      S_BCHK: begin
        if (!stat_i.op_other && stat_i.op == OP_CLOSE) begin
          ctl_o.depth_op = D_INC;
        end else if (!stat_i.op_other && stat_i.op == OP_OPEN) begin
          if (stat_i.depth_one) begin
            ctl_o.pc_op   = PC_P1;
            ctl_o.res_set = 1'b1;
          end else begin
            ctl_o.depth_op = D_DEC;
          end
        end
      end
      S_TCLR: begin
        ctl_o.clr_tape = 1'b1;
        if (stat_i.clr_last_tape) ctl_o.res_set = 1'b1;
      end
      S_RESP: begin
        ctl_o.out_load = out_free;
      end
      default: begin
        ctl_o.ra_sel = RA_PC;
      end
    endcase
  end

  assign out_valid_d = ctl_o.out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
